@@ rtl/core/pngu_pkg.sv @@
package pngu_pkg;

    localparam int MAX_LINE_BYTES  = 16384;
    localparam int MAX_PIXEL_BYTES = 8;

    localparam int LINE_AW = $clog2(MAX_LINE_BYTES);
    localparam int SLOT_W  = $clog2(MAX_PIXEL_BYTES) > 0 ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int POS_W   = 15;
    localparam int BPP_W   = 4;
    localparam int CFG_W   = 15;

    // filter types
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;
    localparam logic [7:0] FILT_MAX   = 8'd4;

    // configuration register indexes
    localparam logic REG_BYTES_PER_PIXEL = 1'b0;
    localparam logic REG_LINE_BYTES      = 1'b1;

    function automatic logic [7:0] paeth_predict(input logic [7:0] a, input logic [7:0] b,
                                                 input logic [7:0] c);
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        logic [9:0] ab;
        logic [9:0] cc;
        ab = {2'b00, a} + {2'b00, b};
        cc = {1'b0, c, 1'b0};
        pa = (b > c) ? ({2'b00, b} - {2'b00, c}) : ({2'b00, c} - {2'b00, b});
        pb = (a > c) ? ({2'b00, a} - {2'b00, c}) : ({2'b00, c} - {2'b00, a});
        pc = (ab > cc) ? (ab - cc) : (cc - ab);
        if (pa <= pb && pa <= pc)
            paeth_predict = a;
        else if (pb <= pc)
            paeth_predict = b;
        else
            paeth_predict = c;
    endfunction

endpackage

@@ rtl/core/pngu_in_if.sv @@
interface pngu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       image_start;

    modport source (output valid, output in_byte, output image_start, input ready);
    modport sink (input valid, input in_byte, input image_start, output ready);
endinterface

@@ rtl/core/pngu_out_if.sv @@
interface pngu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       row_last;
    logic       bad_filter;

    modport source (output valid, output pixel_byte, output row_last, output bad_filter,
                    input ready);
    modport sink (input valid, input pixel_byte, input row_last, input bad_filter,
                  output ready);
endinterface

@@ rtl/core/png_scanline_unfilter_core.sv @@
// png scanline unfilter: rebuilds image bytes from the inflated png stream
// filtered channel: one word per byte; image_start marks the filter byte of the
//   first row of an image; each row is a filter byte then line_bytes data bytes
// pixels channel: one word per reconstructed byte, row_last on the last byte of
//   a row; a filter type above 4 gives one word with bad_filter set and the
//   image is dropped until the next image_start
// cfg port: write bytes_per_pixel (index 0) and line_bytes (index 1) while idle
// a data byte passes the work stage register, then the output register driving pixels
// throughput: one byte per cycle while pixels is not stalled; each byte does one line
//   store read when accepted, and each data byte one write when its result is produced
// filter bytes and dropped bytes give no word and leave the work stage without waiting on pixels
// stall: a held output word keeps its value; the stage behind it fills, then
//   filtered.ready drops until pixels.ready returns
// reset: configuration goes to 1 and 1, the next byte is taken as the filter
//   byte of a first row; the line store is not cleared, a first row never uses it
module png_scanline_unfilter_core
    import pngu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    pngu_in_if.sink          filtered,
    pngu_out_if.source       pixels,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // configuration
    logic [BPP_W-1:0] bpp_reg;
    logic [POS_W-1:0] line_bytes_reg;

    // row control
    logic [POS_W-1:0]  pos_reg;
    logic [2:0]        row_filter_reg;
    logic              first_row_reg;
    logic              awaiting_reg;
    logic              discarding_reg;
    logic [SLOT_W-1:0] cnt_reg [MAX_PIXEL_BYTES];

    logic [POS_W-1:0]  pos_next;
    logic [2:0]        row_filter_next;
    logic              first_row_next;
    logic              awaiting_next;
    logic              discarding_next;
    logic [SLOT_W-1:0] cnt_next [MAX_PIXEL_BYTES];

    // work stage
    logic              s1_valid_reg;
    logic              s1_data_reg;
    logic              s1_err_reg;
    logic [7:0]        s1_byte_reg;
    logic [2:0]        s1_filter_reg;
    logic              s1_first_reg;
    logic              s1_left_ok_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [LINE_AW-1:0] s1_addr_reg;
    logic              s1_last_reg;
    logic [7:0]        rd_reg;

    logic              s1_data_next;
    logic              s1_err_next;
    logic              s1_left_ok_next;
    logic [SLOT_W-1:0] s1_slot_next;
    logic              s1_last_next;

    // output
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_bad_reg;

    logic [7:0] left_hist_reg [MAX_PIXEL_BYTES];
    logic [7:0] up_left_hist_reg [MAX_PIXEL_BYTES];
    logic [7:0] line_mem [MAX_LINE_BYTES];

    logic              accept;
    logic              s1_result;
    logic              s1_go;
    logic [BPP_W-1:0]  eff_bpp;
    logic [POS_W-1:0]  eff_len;
    logic              cur_discarding;
    logic              cur_awaiting;
    logic              cur_first;
    logic [POS_W-1:0]  cur_pos;
    logic [SLOT_W-1:0] cur_cnt [MAX_PIXEL_BYTES];
    logic [POS_W:0]    pos_inc;
    logic [SLOT_W-1:0] bpp_sel;

    logic [7:0] a_val;
    logic [7:0] b_val;
    logic [7:0] c_val;
    logic [8:0] ab_sum;
    logic [7:0] pred;
    logic [7:0] recon;

    assign s1_result = s1_data_reg || s1_err_reg;
    assign s1_go = s1_valid_reg && (!s1_result || !out_valid_reg || pixels.ready);
    assign filtered.ready = !s1_valid_reg || s1_go;
    assign accept = filtered.valid && filtered.ready;

    assign pixels.valid      = out_valid_reg;
    assign pixels.pixel_byte = out_byte_reg;
    assign pixels.row_last   = out_last_reg;
    assign pixels.bad_filter = out_bad_reg;

    always_comb
    begin
        if (bpp_reg == '0)
            eff_bpp = BPP_W'(1);
        else if (bpp_reg > BPP_W'(MAX_PIXEL_BYTES))
            eff_bpp = BPP_W'(MAX_PIXEL_BYTES);
        else
            eff_bpp = bpp_reg;

        if (line_bytes_reg == '0)
            eff_len = POS_W'(1);
        else if (line_bytes_reg > POS_W'(MAX_LINE_BYTES))
            eff_len = POS_W'(MAX_LINE_BYTES);
        else
            eff_len = line_bytes_reg;
    end

    assign bpp_sel = SLOT_W'(eff_bpp - BPP_W'(1));

    // row control, decided when the word is accepted
    always_comb
    begin
        cur_discarding = filtered.image_start ? 1'b0 : discarding_reg;
        cur_awaiting   = filtered.image_start ? 1'b1 : awaiting_reg;
        cur_first      = filtered.image_start ? 1'b1 : first_row_reg;
        cur_pos        = filtered.image_start ? '0 : pos_reg;
        for (int k = 0; k < MAX_PIXEL_BYTES; k++)
            cur_cnt[k] = filtered.image_start ? '0 : cnt_reg[k];
        pos_inc = {1'b0, cur_pos} + (POS_W+1)'(1);

        discarding_next = cur_discarding;
        awaiting_next   = cur_awaiting;
        first_row_next  = cur_first;
        pos_next        = cur_pos;
        row_filter_next = row_filter_reg;
        for (int k = 0; k < MAX_PIXEL_BYTES; k++)
            cnt_next[k] = cur_cnt[k];

        s1_data_next    = 1'b0;
        s1_err_next     = 1'b0;
        s1_left_ok_next = ({1'b0, cur_pos} >= (POS_W+1)'(eff_bpp));
        s1_slot_next    = cur_cnt[bpp_sel];
        s1_last_next    = (pos_inc >= {1'b0, eff_len});

        if (cur_discarding)
        begin
            // dropped word
        end
        else if (cur_awaiting)
        begin
            if (filtered.in_byte > FILT_MAX)
            begin
                discarding_next = 1'b1;
                s1_err_next     = 1'b1;
            end
            else
            begin
                row_filter_next = filtered.in_byte[2:0];
                awaiting_next   = 1'b0;
                pos_next        = '0;
                for (int k = 0; k < MAX_PIXEL_BYTES; k++)
                    cnt_next[k] = '0;
            end
        end
        else
        begin
            s1_data_next = 1'b1;
            if (s1_last_next)
            begin
                awaiting_next  = 1'b1;
                first_row_next = 1'b0;
                pos_next       = '0;
                for (int k = 0; k < MAX_PIXEL_BYTES; k++)
                    cnt_next[k] = '0;
            end
            else
            begin
                pos_next = pos_inc[POS_W-1:0];
                // one position counter per pixel size keeps pos mod size ready
                for (int k = 0; k < MAX_PIXEL_BYTES; k++)
                    cnt_next[k] = (cur_cnt[k] == SLOT_W'(k)) ? '0 : cur_cnt[k] + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg        <= BPP_W'(1);
            line_bytes_reg <= POS_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BYTES_PER_PIXEL: bpp_reg        <= cfg_data[BPP_W-1:0];
                REG_LINE_BYTES:      line_bytes_reg <= cfg_data[POS_W-1:0];
                default:             bpp_reg        <= bpp_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            row_filter_reg <= FILT_NONE;
            first_row_reg  <= 1'b1;
            awaiting_reg   <= 1'b1;
            discarding_reg <= 1'b0;
            for (int k = 0; k < MAX_PIXEL_BYTES; k++)
                cnt_reg[k] <= '0;
        end
        else if (accept)
        begin
            pos_reg        <= pos_next;
            row_filter_reg <= row_filter_next;
            first_row_reg  <= first_row_next;
            awaiting_reg   <= awaiting_next;
            discarding_reg <= discarding_next;
            for (int k = 0; k < MAX_PIXEL_BYTES; k++)
                cnt_reg[k] <= cnt_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_data_reg  <= 1'b0;
            s1_err_reg   <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_data_reg  <= s1_data_next;
            s1_err_reg   <= s1_err_next;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
            s1_data_reg  <= 1'b0;
            s1_err_reg   <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg    <= filtered.in_byte;
            s1_filter_reg  <= row_filter_reg;
            s1_first_reg   <= cur_first;
            s1_left_ok_reg <= s1_left_ok_next;
            s1_slot_reg    <= s1_slot_next;
            s1_addr_reg    <= cur_pos[LINE_AW-1:0];
            s1_last_reg    <= s1_last_next;
        end
    end

    // line store: read when the word comes in, written when its result leaves
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= line_mem[cur_pos[LINE_AW-1:0]];
        if (s1_go && s1_data_reg)
            line_mem[s1_addr_reg] <= recon;
    end

    always_comb
    begin
        a_val  = s1_left_ok_reg ? left_hist_reg[s1_slot_reg] : 8'd0;
        b_val  = s1_first_reg ? 8'd0 : rd_reg;
        c_val  = (s1_left_ok_reg && !s1_first_reg) ? up_left_hist_reg[s1_slot_reg] : 8'd0;
        ab_sum = {1'b0, a_val} + {1'b0, b_val};
        case (s1_filter_reg)
            FILT_SUB:   pred = a_val;
            FILT_UP:    pred = b_val;
            FILT_AVG:   pred = ab_sum[8:1];
            FILT_PAETH: pred = paeth_predict(a_val, b_val, c_val);
            default:    pred = 8'd0;
        endcase
        recon = s1_byte_reg + pred;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++)
            begin
                left_hist_reg[k]    <= 8'd0;
                up_left_hist_reg[k] <= 8'd0;
            end
        end
        else if (s1_go && s1_data_reg)
        begin
            left_hist_reg[s1_slot_reg]    <= recon;
            up_left_hist_reg[s1_slot_reg] <= b_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && s1_result)
            out_valid_reg <= 1'b1;
        else if (pixels.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_result)
        begin
            out_byte_reg <= s1_err_reg ? 8'd0 : recon;
            out_last_reg <= s1_err_reg ? 1'b0 : s1_last_reg;
            out_bad_reg  <= s1_err_reg;
        end
    end

endmodule
